@@ sv/bilinear_thrust_allocation_defines.svh @@
`ifndef BILINEAR_THRUST_ALLOCATION_DEFINES_SVH
`define BILINEAR_THRUST_ALLOCATION_DEFINES_SVH

// next-cycle check, masked while reset is high
`define BTA_ASSERT_NEXT(label, antecedent, consequent) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (antecedent) |=> (consequent)) else $error("bilinear_thrust_allocation port check failed");

// check of what follows a reset cycle
`define BTA_ASSERT_RESET(label, consequent) \
   label: assert property (@(posedge clock) reset |=> consequent) \
      else $error("bilinear_thrust_allocation reset check failed");

`endif

@@ sv/btalloc_pkg.sv @@
package btalloc_pkg;

   localparam int TABLE_SIZE    = 201;
   localparam int LAST_IDX      = TABLE_SIZE - 1;
   localparam int ENTRIES       = TABLE_SIZE * TABLE_SIZE;
   localparam int ADDR_W        = $clog2(ENTRIES);
   localparam int GRID_OFFSET   = 100;
   localparam int IDX_W         = 8;
   localparam int DATA_W        = 16;
   localparam int FRAC_BITS_DEF = 8;
   localparam int FRAC_MAX      = 16;
   localparam int CMD_DEPTH     = 2;
   localparam int RSP_DEPTH     = 4;

   typedef enum logic [1:0] {
      MODE_WR_LEFT  = 2'd0,
      MODE_WR_RIGHT = 2'd1,
      MODE_QUERY    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type                   kind;
      logic [IDX_W-1:0]           row;
      logic [IDX_W-1:0]           row_nx;
      logic [IDX_W-1:0]           col;
      logic [IDX_W-1:0]           col_nx;
      logic [FRAC_MAX-1:0]        wrow;
      logic [FRAC_MAX-1:0]        wcol;
      logic signed [DATA_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   left_drive;
      logic signed [DATA_W-1:0]   right_drive;
   } rsp_type;

endpackage

@@ sv/btalloc_ram.sv @@
module btalloc_ram #(
   parameter int WIDTH = btalloc_pkg::DATA_W,
   parameter int DEPTH = btalloc_pkg::ENTRIES
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/btalloc_fifo.sv @@
module btalloc_fifo #(
   parameter int WIDTH = btalloc_pkg::DATA_W,
   parameter int DEPTH = btalloc_pkg::CMD_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       valid,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ sv/btalloc_front.sv @@
module btalloc_front #(
   parameter int FRAC_BITS = btalloc_pkg::FRAC_BITS_DEF
) (
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_mode,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_force_x,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_moment_n,
   input  logic [btalloc_pkg::IDX_W-1:0]          req_entry_row,
   input  logic [btalloc_pkg::IDX_W-1:0]          req_entry_col,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_entry_value,
   input  logic                                   cmd_full,
   output logic                                   cmd_push,
   output btalloc_pkg::cmd_type                   cmd_data
);

   import btalloc_pkg::*;

   localparam int SW = (FRAC_BITS + 9 > DATA_W + 1) ? FRAC_BITS + 9 : DATA_W + 1;
   localparam logic signed [SW-1:0] LIM = SW'(GRID_OFFSET * (2 ** FRAC_BITS));

   logic signed [SW-1:0] fx_ext, mn_ext, fx_sat, mn_sat;
   logic [SW-1:0]        fx_u, mn_u;
   logic [IDX_W-1:0]     fx_i, mn_j;
   logic                 accept, is_query, is_write, wr_ok;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !req_stall;
   assign is_query  = (req_mode == MODE_QUERY);
   assign is_write  = req_mode inside {MODE_WR_LEFT, MODE_WR_RIGHT};
   assign wr_ok     = (req_entry_row < IDX_W'(TABLE_SIZE)) && (req_entry_col < IDX_W'(TABLE_SIZE));
   assign cmd_push  = accept && (is_query || (is_write && wr_ok));

   always_comb begin
      fx_ext = SW'(req_force_x);
      mn_ext = SW'(req_moment_n);
      if (fx_ext > LIM) begin
         fx_sat = LIM;
      end else if (fx_ext < -LIM) begin
         fx_sat = -LIM;
      end else begin
         fx_sat = fx_ext;
      end
      if (mn_ext > LIM) begin
         mn_sat = LIM;
      end else if (mn_ext < -LIM) begin
         mn_sat = -LIM;
      end else begin
         mn_sat = mn_ext;
      end
      fx_u = fx_sat + LIM;
      mn_u = mn_sat + LIM;
      fx_i = fx_u[FRAC_BITS +: IDX_W];
      mn_j = mn_u[FRAC_BITS +: IDX_W];
   end

   always_comb begin
      case (req_mode)
         MODE_WR_LEFT:  cmd_data.kind = MODE_WR_LEFT;
         MODE_WR_RIGHT: cmd_data.kind = MODE_WR_RIGHT;
         default:       cmd_data.kind = MODE_QUERY;
      endcase
      cmd_data.value = req_entry_value;
      cmd_data.wrow  = FRAC_MAX'(fx_u[FRAC_BITS-1:0]);
      cmd_data.wcol  = FRAC_MAX'(mn_u[FRAC_BITS-1:0]);
      if (is_query) begin
         cmd_data.row    = fx_i;
         cmd_data.row_nx = (fx_i == IDX_W'(LAST_IDX)) ? fx_i : fx_i + 1'b1;
         cmd_data.col    = mn_j;
         cmd_data.col_nx = (mn_j == IDX_W'(LAST_IDX)) ? mn_j : mn_j + 1'b1;
      end else begin
         cmd_data.row    = req_entry_row;
         cmd_data.row_nx = req_entry_row;
         cmd_data.col    = req_entry_col;
         cmd_data.col_nx = req_entry_col;
      end
   end

endmodule

@@ sv/btalloc_back.sv @@
module btalloc_back #(
   parameter int FRAC_BITS = btalloc_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cmd_valid,
   input  btalloc_pkg::cmd_type                   cmd_data,
   output logic                                   cmd_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [btalloc_pkg::DATA_W-1:0]  rsp_left_drive,
   output logic signed [btalloc_pkg::DATA_W-1:0]  rsp_right_drive
);

   import btalloc_pkg::*;

   localparam int WW  = FRAC_BITS + 1;
   localparam int PW  = DATA_W + WW + 1;
   localparam int FW  = PW + WW + 1;
   localparam int RCW = $clog2(RSP_DEPTH + 1);
   localparam logic [WW-1:0]        ONE         = WW'(1) << FRAC_BITS;
   localparam logic signed [FW-1:0] HALF        = FW'(1) << (2 * FRAC_BITS - 1);
   localparam logic [ADDR_W-1:0]    ROW_STRIDE  = ADDR_W'(TABLE_SIZE);
   localparam logic [1:0]           LAST_CORNER = 2'b11;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  k_ff, k_in;
   cmd_type     cur_ff, cur_in;
   logic [RCW-1:0] inflight_ff, inflight_in;

   logic           ready, credit_ok, head_query, take, start, done;
   logic [RCW-1:0] out_count;
   logic           out_full;
   rsp_type        out_data, out_head;

   logic [IDX_W-1:0]  row_sel, col_sel;
   logic [ADDR_W-1:0] ram_addr;
   logic              we_l, we_r;
   logic [DATA_W-1:0] rd_l, rd_r;
   logic [WW-1:0]     e_w, d_w, wcol_cur, wrow_cur;

   logic              s0_valid_ff;
   logic [1:0]        s0_k_ff;
   logic [WW-1:0]     s0_wcol_ff, s0_wrow_ff;

   logic              a_valid_ff;
   logic [1:0]        a_k_ff;
   logic [WW-1:0]     a_wrow_ff;
   logic signed [PW-1:0] a_prod_l_in, a_prod_r_in, a_prod_l_ff, a_prod_r_ff;
   logic signed [PW-1:0] hold_l_ff, hold_r_ff;

   logic              b_valid_ff, b_last_ff;
   logic [WW-1:0]     b_wrow_ff;
   logic signed [PW-1:0] b_sum_l_in, b_sum_r_in, b_sum_l_ff, b_sum_r_ff;

   logic              c_valid_ff, c_last_ff;
   logic signed [FW-1:0] c_prod_l_in, c_prod_r_in, c_prod_l_ff, c_prod_r_ff;
   logic signed [FW-1:0] fin_l_ff, fin_r_ff, acc_l, acc_r;

   // command sequencing
   assign ready      = (state_ff == ST_IDLE) || (state_ff == ST_WRITE) ||
                       ((state_ff == ST_READ) && (k_ff == LAST_CORNER));
   assign credit_ok  = ({1'b0, inflight_ff} + {1'b0, out_count}) < (RCW + 1)'(RSP_DEPTH);
   assign head_query = (cmd_data.kind == MODE_QUERY);
   assign take       = ready && cmd_valid && (!head_query || credit_ok);
   assign cmd_pop    = take;
   assign start      = take && head_query;
   assign done       = c_valid_ff && c_last_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      case (state_ff)
         ST_IDLE, ST_WRITE: state_in = ST_IDLE;
         ST_READ: begin
            if (k_ff != LAST_CORNER) begin
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (take) begin
         cur_in   = cmd_data;
         k_in     = '0;
         state_in = head_query ? ST_READ : ST_WRITE;
      end
   end

   always_comb begin
      inflight_in = inflight_ff;
      case ({start, done})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         k_ff        <= '0;
         inflight_ff <= '0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // table access: corner order (i,j) (i,j+1) (i+1,j) (i+1,j+1)
   always_comb begin
      row_sel  = ((state_ff == ST_READ) && k_ff[1]) ? cur_ff.row_nx : cur_ff.row;
      col_sel  = ((state_ff == ST_READ) && k_ff[0]) ? cur_ff.col_nx : cur_ff.col;
      ram_addr = ADDR_W'(row_sel) * ROW_STRIDE + ADDR_W'(col_sel);
      we_l     = (state_ff == ST_WRITE) && (cur_ff.kind == MODE_WR_LEFT);
      we_r     = (state_ff == ST_WRITE) && (cur_ff.kind == MODE_WR_RIGHT);
      e_w      = {1'b0, cur_ff.wcol[FRAC_BITS-1:0]};
      d_w      = {1'b0, cur_ff.wrow[FRAC_BITS-1:0]};
      wcol_cur = k_ff[0] ? e_w : ONE - e_w;
      wrow_cur = k_ff[1] ? d_w : ONE - d_w;
   end

   btalloc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_left_table (
      .clock (clock),
      .we    (we_l),
      .addr  (ram_addr),
      .wdata (cur_ff.value),
      .rdata (rd_l)
   );

   btalloc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_right_table (
      .clock (clock),
      .we    (we_r),
      .addr  (ram_addr),
      .wdata (cur_ff.value),
      .rdata (rd_r)
   );

   // interpolation pipeline: column weight, row sum, row weight, final sum
   always_comb begin
      a_prod_l_in = $signed(rd_l) * $signed({1'b0, s0_wcol_ff});
      a_prod_r_in = $signed(rd_r) * $signed({1'b0, s0_wcol_ff});
      b_sum_l_in  = hold_l_ff + a_prod_l_ff;
      b_sum_r_in  = hold_r_ff + a_prod_r_ff;
      c_prod_l_in = b_sum_l_ff * $signed({1'b0, b_wrow_ff});
      c_prod_r_in = b_sum_r_ff * $signed({1'b0, b_wrow_ff});
      acc_l       = fin_l_ff + c_prod_l_ff + HALF;
      acc_r       = fin_r_ff + c_prod_r_ff + HALF;
      out_data.left_drive  = acc_l[2 * FRAC_BITS +: DATA_W];
      out_data.right_drive = acc_r[2 * FRAC_BITS +: DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
      end else begin
         s0_valid_ff <= (state_ff == ST_READ);
         a_valid_ff  <= s0_valid_ff;
         b_valid_ff  <= a_valid_ff && a_k_ff[0];
         c_valid_ff  <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_k_ff     <= k_ff;
      s0_wcol_ff  <= wcol_cur;
      s0_wrow_ff  <= wrow_cur;
      a_k_ff      <= s0_k_ff;
      a_wrow_ff   <= s0_wrow_ff;
      a_prod_l_ff <= a_prod_l_in;
      a_prod_r_ff <= a_prod_r_in;
      if (a_valid_ff && !a_k_ff[0]) begin
         hold_l_ff <= a_prod_l_ff;
         hold_r_ff <= a_prod_r_ff;
      end
      b_last_ff   <= a_k_ff[1];
      b_wrow_ff   <= a_wrow_ff;
      b_sum_l_ff  <= b_sum_l_in;
      b_sum_r_ff  <= b_sum_r_in;
      c_last_ff   <= b_last_ff;
      c_prod_l_ff <= c_prod_l_in;
      c_prod_r_ff <= c_prod_r_in;
      if (c_valid_ff && !c_last_ff) begin
         fin_l_ff <= c_prod_l_ff;
         fin_r_ff <= c_prod_r_ff;
      end
   end

   // result queue, space reserved per started query
   btalloc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (done),
      .wdata (out_data),
      .full  (out_full),
      .pop   (!rsp_stall),
      .rdata (out_head),
      .valid (rsp_valid),
      .count (out_count)
   );

   assign rsp_left_drive  = out_head.left_drive;
   assign rsp_right_drive = out_full ? out_head.right_drive : out_head.right_drive;

endmodule

@@ sv/bilinear_thrust_allocation.sv @@
// Twin-thruster allocation by bilinear lookup in a left and a right table of 201 x 201
// signed drive values. A mode 0 or 1 transfer writes one entry; writes outside the grid
// and mode 3 are dropped. A mode 2 transfer saturates force and moment to +/-100, indexes
// the grid and returns both drives rounded to the same fixed point: each query holds the
// single table port for its corner reads (one corner read per cycle, both tables at once;
// the next query may start at the last read, if result space is free), and writes go one
// per cycle while no query holds the port. A result passes stages s0, a, b, c and the
// result queue. Tables are not cleared at reset and read undefined until written; a 2-deep
// command queue and a 4-deep result queue let either side stall independently.
module bilinear_thrust_allocation #(
   parameter int FRAC_BITS = btalloc_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_mode,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_force_x,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_moment_n,
   input  logic [btalloc_pkg::IDX_W-1:0]          req_entry_row,
   input  logic [btalloc_pkg::IDX_W-1:0]          req_entry_col,
   input  logic signed [btalloc_pkg::DATA_W-1:0]  req_entry_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [btalloc_pkg::DATA_W-1:0]  rsp_left_drive,
   output logic signed [btalloc_pkg::DATA_W-1:0]  rsp_right_drive
);

   import btalloc_pkg::*;

   logic    cmd_full, cmd_push, cmd_valid, cmd_pop;
   cmd_type cmd_in, cmd_head;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

   btalloc_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_force_x     (req_force_x),
      .req_moment_n    (req_moment_n),
      .req_entry_row   (req_entry_row),
      .req_entry_col   (req_entry_col),
      .req_entry_value (req_entry_value),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in)
   );

   btalloc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_in),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_head),
      .valid (cmd_valid),
      .count (cmd_count)
   );

   btalloc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid && (cmd_count != '0)),
      .cmd_data        (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive)
   );

endmodule

@@ sv/btalloc_checker.sv @@
`include "bilinear_thrust_allocation_defines.svh"

module btalloc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_left_drive,
   input logic [15:0] rsp_right_drive
);

   // hold a stalled result
   `BTA_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && rsp_stall, rsp_valid)
   `BTA_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && rsp_stall, $stable(rsp_left_drive) && $stable(rsp_right_drive))
   // empty queues after reset
   `BTA_ASSERT_RESET(a_req_open_after_reset, !req_stall)
   `BTA_ASSERT_RESET(a_no_early_rsp, !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
   // no input stall without a pending transfer history
   `BTA_ASSERT_NEXT(a_stall_needs_traffic, !req_valid && !rsp_valid, !req_stall || $past(req_stall))

endmodule

bind bilinear_thrust_allocation btalloc_checker u_btalloc_checker (.*);
